### sv/mcs_pkg.sv
// Shared types and constants for the multiplexed counter scaler.
// Used by mcs_ctrl, mcs_dp and multiplexed_counter_scaler_unit; no dependencies.
package mcs_pkg;

  // Default number of per-CPU entries
  localparam int NUM_CPUS_DEF = 32;

  // Field widths
  localparam int CPU_W  = 5;
  localparam int VAL_W  = 64;
  localparam int STAT_W = 2;

  // Stream data widths (padded to whole bytes)
  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 128;

  // Reset value of the delta limit register
  localparam logic [VAL_W-1:0] DELTA_LIMIT_RST = 64'd2000000000000;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_ADDED        = 2'd0;
  localparam logic [STAT_W-1:0] ST_INCONSISTENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER_LIMIT   = 2'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT       = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture request, read per-CPU memory
    logic check;      // form deltas, write back new triple
    logic mul_start;  // clear product accumulator
    logic mul_step;   // one partial product
    logic div_init;   // load dividend, saturation check
    logic div_step;   // one quotient bit
    logic round;      // round half up, saturate
    logic finish;     // limit check, sum update, load output register
  } mcs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic present;    // counter present and CPU in range
    logic bad;        // inconsistent reading
    logic mul_last;   // last accumulate cycle of the multiply
    logic div_last;   // last quotient bit
    logic out_free;   // output register can take a result
  } mcs_stat_t;

endpackage

### sv/mcs_ctrl.sv
// Sequencing state machine of the multiplexed counter scaler.
// Depends on mcs_pkg for the command and status structs.
module mcs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  mcs_pkg::mcs_stat_t st,
  output mcs_pkg::mcs_cmd_t  cmd
);
  import mcs_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_EVAL  = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_DINIT = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_RND   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_CHECK;
      S_CHECK: state_next = st.present ? S_EVAL : S_FIN;
      S_EVAL:  state_next = st.bad ? S_FIN : S_MUL;
      S_MUL:   if (st.mul_last) state_next = S_DINIT;
      S_DINIT: state_next = S_DIV;
      S_DIV:   if (st.div_last) state_next = S_RND;
      S_RND:   state_next = S_FIN;
      S_FIN:   if (st.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  assign s_tready      = (state == S_IDLE);
  assign cmd.load      = (state == S_IDLE) && s_tvalid;
  assign cmd.check     = (state == S_CHECK);
  assign cmd.mul_start = (state == S_EVAL);
  assign cmd.mul_step  = (state == S_MUL);
  assign cmd.div_init  = (state == S_DINIT);
  assign cmd.div_step  = (state == S_DIV);
  assign cmd.round     = (state == S_RND);
  assign cmd.finish    = (state == S_FIN) && st.out_free;

endmodule

### sv/mcs_dp.sv
// Datapath of the multiplexed counter scaler: per-CPU memory, multiplier,
// radix-2 divider, sweep sum, limit register and output register. Uses mcs_pkg.
module mcs_dp #(
  parameter int NUM_CPUS = mcs_pkg::NUM_CPUS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mcs_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mcs_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [mcs_pkg::STAT_W-1:0]      m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  input  logic [mcs_pkg::VAL_W-1:0]       cfg_data,
  input  mcs_pkg::mcs_cmd_t               cmd,
  output mcs_pkg::mcs_stat_t              st
);
  import mcs_pkg::*;

  localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int ENT_W = 3 * VAL_W;

  // Request field decode
  logic [CPU_W-1:0] cpu_in;
  logic [VAL_W-1:0] cnt_in, en_in, run_in;
  logic [8:0]       cpu_ext;
  logic [IDX_W-1:0] addr_in;
  logic             in_range;

  assign cpu_in   = s_tdata[4:0];
  assign cnt_in   = s_tdata[68:5];
  assign en_in    = s_tdata[132:69];
  assign run_in   = s_tdata[196:133];
  assign cpu_ext  = 9'(cpu_in);
  assign addr_in  = cpu_ext[IDX_W-1:0];
  assign in_range = (cpu_ext < 9'(NUM_CPUS));

  // Captured request
  logic [IDX_W-1:0] addr;
  logic [VAL_W-1:0] cnt, en, run;
  logic             last, present;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr    <= addr_in;
      cnt     <= cnt_in;
      en      <= en_in;
      run     <= run_in;
      last    <= s_tlast;
      present <= s_tuser && in_range;
    end
  end

  // Per-CPU previous triple: memory with registered read, valid bits in flops
  logic [ENT_W-1:0]    mem [NUM_CPUS];
  logic [ENT_W-1:0]    rd;
  logic                rd_vld;
  logic [NUM_CPUS-1:0] vld;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd <= mem[addr_in];
    end
    if (cmd.check && present) begin
      mem[addr] <= {run, en, cnt};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_vld <= vld[addr_in];
      end
      if (cmd.check && present) begin
        vld[addr] <= 1'b1;
      end
    end
  end

  // Deltas and consistency check
  logic [VAL_W-1:0] pc, pe, pr;
  logic [VAL_W:0]   sub_c, sub_e, sub_r;
  logic [VAL_W-1:0] dcnt, den, drun;
  logic             bad;

  assign pc    = rd_vld ? rd[VAL_W-1:0]         : '0;
  assign pe    = rd_vld ? rd[2*VAL_W-1:VAL_W]   : '0;
  assign pr    = rd_vld ? rd[ENT_W-1:2*VAL_W]   : '0;
  assign sub_c = {1'b0, cnt} - {1'b0, pc};
  assign sub_e = {1'b0, en}  - {1'b0, pe};
  assign sub_r = {1'b0, run} - {1'b0, pr};

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      dcnt <= sub_c[VAL_W-1:0];
      den  <= sub_e[VAL_W-1:0];
      drun <= sub_r[VAL_W-1:0];
      bad  <= sub_c[VAL_W] || sub_e[VAL_W] || sub_r[VAL_W] ||
              (sub_r[VAL_W-1:0] == '0);
    end
  end

  // 64x64 multiply: four 32x32 partial products, each registered before it is accumulated
  logic [2:0]         mstep;
  logic [63:0]        pp;
  logic [1:0]         pp_sh;
  logic               pp_v;
  logic [127:0]       prod;
  logic [31:0]        mul_a, mul_b;

  assign mul_a = mstep[0] ? dcnt[63:32] : dcnt[31:0];
  assign mul_b = mstep[1] ? den[63:32]  : den[31:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mstep <= '0;
      pp_v  <= 1'b0;
      prod  <= '0;
    end else if (cmd.mul_step) begin
      mstep <= mstep + 3'd1;
      pp_v  <= ~mstep[2];
      pp    <= mul_a * mul_b;
      pp_sh <= {mstep[0] & mstep[1], mstep[0] ^ mstep[1]};
      if (pp_v) begin
        prod <= prod + (128'(pp) << {pp_sh, 5'b0});
      end
    end
  end

  // Restoring radix-2 divide, one quotient bit per cycle
  logic [VAL_W-1:0] rem, lo, q;
  logic [5:0]       dstep;
  logic             sat;
  logic [VAL_W-1:0] sh;
  logic [VAL_W:0]   trial;
  logic             take;

  assign sh    = {rem[VAL_W-2:0], lo[VAL_W-1]};
  assign trial = {1'b0, sh} - {1'b0, drun};
  assign take  = rem[VAL_W-1] || !trial[VAL_W];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem   <= prod[127:64];
      lo    <= prod[63:0];
      q     <= '0;
      dstep <= '0;
      sat   <= (prod[127:64] >= drun);
    end else if (cmd.div_step) begin
      rem   <= take ? trial[VAL_W-1:0] : sh;
      lo    <= {lo[VAL_W-2:0], 1'b0};
      q     <= {q[VAL_W-2:0], take};
      dstep <= dstep + 6'd1;
    end
  end

  // Round half up with saturation
  logic             up;
  logic [VAL_W-1:0] delta;

  assign up = ({rem, 1'b0} >= {1'b0, drun});

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      if (sat || (up && (q == '1))) begin
        delta <= '1;
      end else begin
        delta <= q + VAL_W'(up);
      end
    end
  end

  // Limit register
  logic [VAL_W-1:0] delta_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_limit <= DELTA_LIMIT_RST;
    end else if (cfg_valid) begin
      delta_limit <= cfg_data;
    end
  end

  // Result classification and sweep sum
  logic [STAT_W-1:0] res_stat;
  logic [VAL_W-1:0]  res_delta, sum_new, running_sum;

  always_comb begin
    res_stat  = ST_ADDED;
    res_delta = delta;
    if (!present) begin
      res_stat  = ST_ABSENT;
      res_delta = '0;
    end else if (bad) begin
      res_stat  = ST_INCONSISTENT;
      res_delta = '0;
    end else if (delta > delta_limit) begin
      res_stat  = ST_OVER_LIMIT;
    end
  end

  assign sum_new = running_sum + ((res_stat == ST_ADDED) ? res_delta : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (cmd.finish) begin
      running_sum <= last ? '0 : sum_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {sum_new, res_delta};
      m_tuser <= res_stat;
      m_tlast <= last;
    end
  end

  // Status to controller
  assign st.present  = present;
  assign st.bad      = bad;
  assign st.mul_last = mstep[2];
  assign st.div_last = (dstep == '1);
  assign st.out_free = !m_tvalid || m_tready;

endmodule

### sv/multiplexed_counter_scaler_unit.sv
// Top level of the multiplexed counter scaler: controller plus datapath.
// Depends on mcs_pkg, mcs_ctrl and mcs_dp.
//
//   channel  direction  fields
//   s_*      in         tdata: cpu_index, count_value, time_enabled, time_running;
//                       tuser: counter_present; tlast: sweep_last
//   m_*      out        tdata: scaled_delta, sweep_total; tuser: status;
//                       tlast: sweep_done
//   cfg_*    in         data: delta_limit (always ready)
//
// A present, consistent reading runs through the check, evaluate, multiply,
// divide-init, divide, round and finish states, using the 32x32 multiplier and
// the one-bit-per-cycle divider; an absent reading goes from check to finish.
// One request is in flight at a time; the next is accepted while the previous
// result waits in the output register. A stalled output holds the controller
// in its final state. Reset clears the per-CPU valid bits and the sweep sum,
// and reloads the limit register with its default.
module multiplexed_counter_scaler_unit #(
  parameter int NUM_CPUS = mcs_pkg::NUM_CPUS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [4:0] cpu_index, [68:5] count_value, [132:69] time_enabled,
  // [196:133] time_running, [199:197] zero
  input  logic [mcs_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,   // [0] counter_present
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [63:0] scaled_delta, [127:64] sweep_total
  output logic [mcs_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [mcs_pkg::STAT_W-1:0]      m_tuser,   // [1:0] status
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mcs_pkg::VAL_W-1:0]       cfg_data
);
  import mcs_pkg::*;

  mcs_cmd_t  cmd;
  mcs_stat_t st;

  assign cfg_ready = 1'b1;

  mcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mcs_dp #(
    .NUM_CPUS (NUM_CPUS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

  // One request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while busy");

  // No delta reported for skipped or inconsistent readings
  a_zero_delta: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_ABSENT || m_tuser == ST_INCONSISTENT))
      |-> (m_tdata[63:0] == '0))
    else $error("nonzero delta on skipped or inconsistent result");

  // A result is only produced while a request is in flight
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a request in flight");

endmodule

### verif/multiplexed_counter_scaler_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for multiplexed_counter_scaler_unit: directed and random
// counter readings, each result compared in order against a built-in scaler model.
// Depends on mcs_pkg and the multiplexed_counter_scaler_unit RTL.
module multiplexed_counter_scaler_unit_tb;
  import mcs_pkg::*;

  localparam int NUM_CPUS     = NUM_CPUS_DEF;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [VAL_W-1:0] ALL_ONES = '1;

  // One counter reading as sent on the input stream
  typedef struct {
    logic [CPU_W-1:0] cpu;
    logic             present;
    logic [VAL_W-1:0] count;
    logic [VAL_W-1:0] enabled;
    logic [VAL_W-1:0] running;
    logic             last;
  } reading_t;

  // One scaler result as seen on the output stream
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  delta;
    logic [VAL_W-1:0]  total;
    logic              done;
  } scale_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]     m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [VAL_W-1:0]      cfg_data = '0;

  // Scaler model state
  logic [VAL_W-1:0] last_count   [NUM_CPUS];
  logic [VAL_W-1:0] last_enabled [NUM_CPUS];
  logic [VAL_W-1:0] last_running [NUM_CPUS];
  logic [VAL_W-1:0] sweep_sum;
  logic [VAL_W-1:0] limit_shadow;

  scale_result_t pending_results[$];
  scale_result_t want;
  int            mismatches = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_left = 0;
  int            cycle_count = 0;

  multiplexed_counter_scaler_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_CPUS; i++) begin
      last_count[i]   = '0;
      last_enabled[i] = '0;
      last_running[i] = '0;
    end
    sweep_sum    = '0;
    limit_shadow = DELTA_LIMIT_RST;
  end

  // Scaled delta for one accepted reading; advances the model state
  function automatic scale_result_t scale_reading(reading_t rd);
    scale_result_t   res;
    int unsigned     c;
    logic [VAL_W-1:0] dc, de, dr;
    logic [127:0]    prod, quo, rmd;
    c          = rd.cpu;
    res.status = ST_ABSENT;
    res.delta  = '0;
    if (rd.present && c < NUM_CPUS) begin
      if (rd.count < last_count[c] || rd.enabled < last_enabled[c] ||
          rd.running <= last_running[c]) begin
        res.status = ST_INCONSISTENT;
      end else begin
        dc   = rd.count - last_count[c];
        de   = rd.enabled - last_enabled[c];
        dr   = rd.running - last_running[c];
        prod = {64'd0, dc} * {64'd0, de};
        quo  = prod / {64'd0, dr};
        rmd  = prod % {64'd0, dr};
        // round half up, then saturate to 64 bits
        if (rmd >= {64'd0, dr} - rmd) quo = quo + 1;
        res.delta = (quo[127:64] != 0) ? ALL_ONES : quo[63:0];
        if (res.delta > limit_shadow) begin
          res.status = ST_OVER_LIMIT;
        end else begin
          res.status = ST_ADDED;
          sweep_sum  = sweep_sum + res.delta;
        end
      end
      last_count[c]   = rd.count;
      last_enabled[c] = rd.enabled;
      last_running[c] = rd.running;
    end
    res.total = sweep_sum;
    res.done  = rd.last;
    if (rd.last) sweep_sum = '0;
    return res;
  endfunction

  function automatic logic [VAL_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random value below 2^nb
  function automatic logic [VAL_W-1:0] rand_bits(int unsigned nb);
    logic [VAL_W-1:0] v;
    v = rand64();
    if (nb >= VAL_W) return v;
    return v & ((64'd1 << nb) - 1);
  endfunction

  function automatic reading_t make_reading(int unsigned cpu, logic present,
                                            logic [VAL_W-1:0] cnt, logic [VAL_W-1:0] en,
                                            logic [VAL_W-1:0] run, logic last);
    reading_t rd;
    rd.cpu     = CPU_W'(cpu);
    rd.present = present;
    rd.count   = cnt;
    rd.enabled = en;
    rd.running = run;
    rd.last    = last;
    return rd;
  endfunction

  // Mostly consistent readings that advance a CPU's triple; some absent,
  // fully random or deliberately broken
  function automatic reading_t make_random_reading();
    reading_t         rd;
    int unsigned      kind;
    int unsigned      c;
    logic [VAL_W-1:0] dc, de, dr;
    kind       = $urandom_range(99);
    c          = $urandom_range(NUM_CPUS - 1);
    rd.cpu     = CPU_W'(c);
    rd.present = 1'b1;
    rd.last    = ($urandom_range(7) == 0);
    if (kind < 8) begin
      rd.present = 1'b0;
      rd.count   = rand64();
      rd.enabled = rand64();
      rd.running = rand64();
    end else if (kind < 13) begin
      rd.count   = rand64();
      rd.enabled = rand64();
      rd.running = rand64();
    end else if (kind < 20) begin
      // one field steps backwards, or running stalls
      rd.count   = last_count[c] + rand_bits(20);
      rd.enabled = last_enabled[c] + rand_bits(20);
      rd.running = last_running[c] + 1 + rand_bits(20);
      case ($urandom_range(2))
        0: rd.count = last_count[c] - 1 - rand_bits(8);
        1: rd.enabled = last_enabled[c] - 1 - rand_bits(8);
        default: rd.running = last_running[c] - rand_bits(8);
      endcase
    end else begin
      if (kind < 24) begin
        // huge deltas over a short running time: mostly saturating
        dc = rand64();
        de = rand64();
        dr = 1 + rand_bits($urandom_range(1, 8));
      end else begin
        dc = rand_bits($urandom_range(0, 44));
        de = rand_bits($urandom_range(0, 30));
        dr = (de == 0) ? 1 + rand_bits(10) : 1 + rand64() % de;
      end
      rd.count   = last_count[c] + dc;
      rd.enabled = last_enabled[c] + de;
      rd.running = last_running[c] + dr;
    end
    return rd;
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] exp_val);
    $display("mismatch %s: got %0h, want %0h (t=%0t)", what, got, exp_val, $realtime);
    mismatches++;
  endtask

  // Send one reading; the expected result is queued when the request is taken
  task automatic send_reading(input reading_t rd);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, rd.running, rd.enabled, rd.count, rd.cpu};
    s_tuser  <= rd.present;
    s_tlast  <= rd.last;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(scale_reading(rd));
  endtask

  // Stop offering, wait for every result and for the block to settle
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_delta_limit(input logic [VAL_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_shadow = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output side: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[63:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
        if (m_tdata[63:0] !== want.delta)
          report_mismatch("scaled_delta", m_tdata[63:0], want.delta);
        if (m_tdata[127:64] !== want.total)
          report_mismatch("sweep_total", m_tdata[127:64], want.total);
        if (m_tlast !== want.done) report_mismatch("sweep_done", m_tlast, want.done);
      end
    end
  end

  // Field extremes, rounding, inconsistency kinds, absent and saturation
  task automatic test_directed_cases();
    send_reading(make_reading(0, 1, 0, 0, 0, 0));        // running did not advance
    send_reading(make_reading(0, 1, 100, 200, 50, 0));   // 400 added
    send_reading(make_reading(0, 1, 50, 300, 60, 0));    // count went back
    send_reading(make_reading(0, 1, 60, 250, 70, 0));    // enabled went back
    send_reading(make_reading(0, 1, 61, 251, 72, 0));    // exactly one half rounds up
    send_reading(make_reading(0, 1, 62, 252, 75, 0));    // one third rounds down
    send_reading(make_reading(0, 1, 62, 252, 76, 0));    // zero count delta
    send_reading(make_reading(5, 0, ALL_ONES, ALL_ONES, ALL_ONES, 1));  // absent, sweep end
    send_reading(make_reading(1, 1, ALL_ONES, ALL_ONES, 1, 0));  // saturates, over limit
    send_reading(make_reading(2, 1, 64'd3000000000000, 1, 1, 0));  // over limit
    send_reading(make_reading(3, 1, DELTA_LIMIT_RST, 1, 1, 0));   // exactly at limit
    send_reading(make_reading(31, 1, ALL_ONES, ALL_ONES, ALL_ONES, 0));
    send_reading(make_reading(1, 1, 0, 0, 2, 1));        // inconsistent at sweep end
    send_reading(make_reading(31, 0, 0, 0, 0, 0));
    send_reading(make_reading(0, 1, 62, 252, 76, 1));    // running equal
  endtask

  // Limit of zero and of all ones, with the sweep sum wrapping
  task automatic test_limit_extremes();
    set_delta_limit('0);
    send_reading(make_reading(6, 1, 10, 10, 10, 0));     // 10 over a zero limit
    send_reading(make_reading(6, 1, 10, 20, 20, 1));     // zero delta still added
    set_delta_limit(ALL_ONES);
    send_reading(make_reading(7, 1, 64'h8000_0000_0000_0005, 1, 1, 0));
    send_reading(make_reading(8, 1, 64'h8000_0000_0000_0005, 1, 1, 0));  // sum wraps
    send_reading(make_reading(9, 1, ALL_ONES, ALL_ONES, 1, 1));  // saturated, added
    set_delta_limit(DELTA_LIMIT_RST);
  endtask

  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n_items) send_reading(make_random_reading());
  endtask

  // Output held off while the input keeps offering, so the block fills up
  task automatic test_output_hold();
    send_idle_pct = 0;
    @(posedge clk);
    hold_left = 400;
    repeat (8) send_reading(make_random_reading());
  endtask

  // Input pauses until all results are back, then resumes
  task automatic test_pause_resume();
    send_idle_pct  = 0;
    recv_stall_pct = 30;
    repeat (10) send_reading(make_random_reading());
    wait_idle();
    repeat (10) send_reading(make_random_reading());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct  = 14;
    recv_stall_pct = 87;
    test_directed_cases();
    test_limit_extremes();
    test_random_traffic(600, 14, 87);
    test_output_hold();
    test_pause_resume();
    set_delta_limit(rand_bits(42));
    test_random_traffic(620, 87, 14);
    set_delta_limit(ALL_ONES);
    test_random_traffic(620, 0, 0);
    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
